### rtl/core/led_matrix_serpentine_framebuffer_unit_macros.svh
// Assertion macros shared by the frame buffer RTL.
`ifndef LED_MATRIX_SERPENTINE_FRAMEBUFFER_UNIT_MACROS_SVH
`define LED_MATRIX_SERPENTINE_FRAMEBUFFER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define LMSFB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define LMSFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/lmsfb_pkg.sv
// Shared types, command codes and the color scaling function of the frame buffer.
package lmsfb_pkg;

	localparam int COORD_W = 3;
	localparam int COLOR_W = 8;
	localparam int LEVEL_W = 9;
	localparam int KIND_W  = 3;

	localparam logic [LEVEL_W-1:0] LEVEL_FULL = 9'd256;

	// Command kinds
	localparam logic [KIND_W-1:0] KIND_PIXEL  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_ROW    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_COL    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_BORDER = 3'd3;
	localparam logic [KIND_W-1:0] KIND_MAIN   = 3'd4;
	localparam logic [KIND_W-1:0] KIND_ANTI   = 3'd5;
	localparam logic [KIND_W-1:0] KIND_FILL   = 3'd6;
	localparam logic [KIND_W-1:0] KIND_FLUSH  = 3'd7;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} pixel_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic pixel_wr;
		logic walk_init;
		logic issue;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_pixel;
		logic drop;
		logic s1_free;
		logic walk_last;
	} dp_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_STREAM
	} state_t;

	// Scale one component: (c * level) >> 8
	function automatic logic [COLOR_W-1:0] scale_comp(input logic [COLOR_W-1:0] c,
		input logic [LEVEL_W-1:0] lvl);
		logic [COLOR_W+LEVEL_W-1:0] prod;
		prod = {{LEVEL_W{1'b0}}, c} * {{COLOR_W{1'b0}}, lvl};
		return prod[COLOR_W+7:8];
	endfunction

endpackage

### rtl/core/lmsfb_ifs.sv
// Command and pixel stream channel interfaces.
interface lmsfb_cmd_if;
	logic                                 valid;
	logic                                 ready;
	logic [lmsfb_pkg::KIND_W-1:0]  kind;
	logic [lmsfb_pkg::COORD_W-1:0] pos_x;
	logic [lmsfb_pkg::COORD_W-1:0] pos_y;
	logic [lmsfb_pkg::COLOR_W-1:0] red;
	logic [lmsfb_pkg::COLOR_W-1:0] green;
	logic [lmsfb_pkg::COLOR_W-1:0] blue;
	logic [lmsfb_pkg::LEVEL_W-1:0] level;

	modport source (output valid, kind, pos_x, pos_y, red, green, blue, level, input ready);
	modport sink (input valid, kind, pos_x, pos_y, red, green, blue, level, output ready);
endinterface

interface lmsfb_pix_if;
	logic                                 valid;
	logic                                 ready;
	logic [lmsfb_pkg::COLOR_W-1:0] out_green;
	logic [lmsfb_pkg::COLOR_W-1:0] out_red;
	logic [lmsfb_pkg::COLOR_W-1:0] out_blue;
	logic                                 last;

	modport source (output valid, out_green, out_red, out_blue, last, input ready);
	modport sink (input valid, out_green, out_red, out_blue, last, output ready);
endinterface

### rtl/core/led_matrix_serpentine_framebuffer_unit.sv
// Top level of the serpentine LED matrix frame buffer.
//
// channel  dir  payload                                        handshake
// cmd      in   kind, pos_x, pos_y, red, green, blue, level    valid/ready
// pix      out  out_green, out_red, out_blue, last             valid/ready
//
// Set-pixel and a dropped row or column end in the dispatch state. Other commands
// walk every stored index: the walk issues one store read-modify-write per cycle while
// the output stage is free, through the single store port into the output stage.
// Reset clears the store to black through per-entry valid bits; no clearing pass.
// A stalled pix channel holds the walk; the last pixel may wait while the next
// transaction on cmd is accepted.
`include "led_matrix_serpentine_framebuffer_unit_macros.svh"

module led_matrix_serpentine_framebuffer_unit #(
	parameter int MATRIX_WIDTH  = 5,
	parameter int MATRIX_HEIGHT = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	lmsfb_cmd_if.sink     cmd,
	lmsfb_pix_if.source   pix
);

	lmsfb_pkg::ctl_cmd_t ctl;
	lmsfb_pkg::dp_stat_t stat;

	lmsfb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (cmd.ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	lmsfb_dp #(
		.MATRIX_WIDTH  (MATRIX_WIDTH),
		.MATRIX_HEIGHT (MATRIX_HEIGHT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.stat      (stat),
		.kind      (cmd.kind),
		.pos_x     (cmd.pos_x),
		.pos_y     (cmd.pos_y),
		.red       (cmd.red),
		.green     (cmd.green),
		.blue      (cmd.blue),
		.level     (cmd.level),
		.out_valid (pix.valid),
		.out_ready (pix.ready),
		.out_green (pix.out_green),
		.out_red   (pix.out_red),
		.out_blue  (pix.out_blue),
		.out_last  (pix.last)
	);

	// A store read is issued only when the output stage can take it
	`LMSFB_ASSERT_IMPLY(a_issue_free, clk, arst_n, ctl.issue, stat.s1_free, "issue into busy output stage")

	// An accepted command blocks acceptance of another in the next cycle
	`LMSFB_ASSERT_NEXT(a_accept_busy, clk, arst_n, cmd.valid && cmd.ready, !cmd.ready, "command accepted back to back")

	// Issuing the last stored index returns the sequencer to idle
	`LMSFB_ASSERT_NEXT(a_walk_end, clk, arst_n, ctl.issue && stat.walk_last, cmd.ready, "walk did not end after last index")

endmodule

### rtl/core/lmsfb_ctrl.sv
// Command sequencer: accepts a transaction, dispatches a pixel write or a store walk.
module lmsfb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lmsfb_pkg::dp_stat_t  stat,
	output lmsfb_pkg::ctl_cmd_t  ctl
);

	lmsfb_pkg::state_t state_q;
	lmsfb_pkg::state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lmsfb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		ctl           = '0;
		case (state_q)
			lmsfb_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = lmsfb_pkg::ST_DISPATCH;
				end
			end
			lmsfb_pkg::ST_DISPATCH: begin
				if (stat.is_pixel) begin
					ctl.pixel_wr = 1'b1;
					state_d      = lmsfb_pkg::ST_IDLE;
				end else if (stat.drop) begin
					state_d = lmsfb_pkg::ST_IDLE;
				end else begin
					ctl.walk_init = 1'b1;
					state_d       = lmsfb_pkg::ST_STREAM;
				end
			end
			lmsfb_pkg::ST_STREAM: begin
				ctl.issue = stat.s1_free;
				if (stat.s1_free && stat.walk_last) begin
					state_d = lmsfb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lmsfb_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/core/lmsfb_dp.sv
// Datapath: command registers, scaled color, pixel store and the stream output stage.
module lmsfb_dp #(
	parameter int MATRIX_WIDTH  = 5,
	parameter int MATRIX_HEIGHT = 5
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lmsfb_pkg::ctl_cmd_t                  ctl,
	output lmsfb_pkg::dp_stat_t                  stat,
	input  logic [lmsfb_pkg::KIND_W-1:0]         kind,
	input  logic [lmsfb_pkg::COORD_W-1:0]        pos_x,
	input  logic [lmsfb_pkg::COORD_W-1:0]        pos_y,
	input  logic [lmsfb_pkg::COLOR_W-1:0]        red,
	input  logic [lmsfb_pkg::COLOR_W-1:0]        green,
	input  logic [lmsfb_pkg::COLOR_W-1:0]        blue,
	input  logic [lmsfb_pkg::LEVEL_W-1:0]        level,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [lmsfb_pkg::COLOR_W-1:0]        out_green,
	output logic [lmsfb_pkg::COLOR_W-1:0]        out_red,
	output logic [lmsfb_pkg::COLOR_W-1:0]        out_blue,
	output logic                                 out_last
);

	localparam int COUNT = MATRIX_WIDTH * MATRIX_HEIGHT;
	localparam int AW    = $clog2(COUNT);
	localparam int XW    = $clog2(MATRIX_WIDTH);
	localparam int YW    = $clog2(MATRIX_HEIGHT);
	localparam int CW    = lmsfb_pkg::COORD_W;

	// Command registers
	logic [lmsfb_pkg::KIND_W-1:0] kind_q;
	logic [CW-1:0]                px_q;
	logic [CW-1:0]                py_q;
	lmsfb_pkg::pixel_t            color_q;
	logic [lmsfb_pkg::LEVEL_W-1:0] lvl_sat;

	// Walk counters
	logic [AW-1:0] idx_q;
	logic [YW-1:0] row_q;
	logic [XW-1:0] col_q;
	logic [XW-1:0] x_cur;
	logic          hit;

	// Pixel store with per-entry valid bits
	lmsfb_pkg::pixel_t mem_q [COUNT];
	logic [COUNT-1:0]  vld_q;
	logic              wr_en;
	logic [AW-1:0]     waddr;

	// Single pixel write address
	logic          pix_in_range;
	logic [CW-1:0] pix_xm;
	logic [AW-1:0] pix_lin;
	logic [AW-1:0] pix_idx;

	// Output stage
	logic              valid_s1;
	lmsfb_pkg::pixel_t data_s1;
	logic              last_s1;

	// Saturate the level and latch the scaled color with the command
	assign lvl_sat = (level > lmsfb_pkg::LEVEL_FULL) ? lmsfb_pkg::LEVEL_FULL : level;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			kind_q        <= kind;
			px_q          <= pos_x;
			py_q          <= pos_y;
			color_q.red   <= lmsfb_pkg::scale_comp(red, lvl_sat);
			color_q.green <= lmsfb_pkg::scale_comp(green, lvl_sat);
			color_q.blue  <= lmsfb_pkg::scale_comp(blue, lvl_sat);
		end
	end

	// Command status
	always_comb begin
		stat.is_pixel  = (kind_q == lmsfb_pkg::KIND_PIXEL);
		stat.drop      = ((kind_q == lmsfb_pkg::KIND_ROW) && (int'(py_q) >= MATRIX_HEIGHT)) ||
			((kind_q == lmsfb_pkg::KIND_COL) && (int'(px_q) >= MATRIX_WIDTH));
		stat.s1_free   = !valid_s1 || out_ready;
		stat.walk_last = (idx_q == AW'(COUNT - 1));
	end

	// Column of the current walk position; odd rows run right to left
	assign x_cur = row_q[0] ? (XW'(MATRIX_WIDTH - 1) - col_q) : col_q;

	// Decide whether the drawing command covers the current pixel
	always_comb begin
		case (kind_q)
			lmsfb_pkg::KIND_ROW:    hit = (CW'(row_q) == py_q);
			lmsfb_pkg::KIND_COL:    hit = (CW'(x_cur) == px_q);
			lmsfb_pkg::KIND_BORDER: hit = (x_cur == '0) || (x_cur == XW'(MATRIX_WIDTH - 1)) ||
				(row_q == '0) || (row_q == YW'(MATRIX_HEIGHT - 1));
			lmsfb_pkg::KIND_MAIN:   hit = (CW'(x_cur) == CW'(row_q));
			lmsfb_pkg::KIND_ANTI:   hit = ((CW+1)'(x_cur) + (CW+1)'(row_q)) ==
				(CW+1)'(MATRIX_WIDTH - 1);
			lmsfb_pkg::KIND_FILL:   hit = 1'b1;
			default:                hit = 1'b0;
		endcase
	end

	// Stored index of a single pixel
	assign pix_in_range = (int'(px_q) < MATRIX_WIDTH) && (int'(py_q) < MATRIX_HEIGHT);
	assign pix_xm       = py_q[0] ? (CW'(MATRIX_WIDTH - 1) - px_q) : px_q;
	assign pix_lin      = AW'(int'(py_q) * MATRIX_WIDTH + int'(pix_xm));
	assign pix_idx      = AW'(COUNT - 1) - pix_lin;

	// Write port select
	assign wr_en = (ctl.issue && hit) || (ctl.pixel_wr && pix_in_range);
	assign waddr = ctl.issue ? idx_q : pix_idx;

	// Advance the walk in stored order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			row_q <= '0;
			col_q <= '0;
		end else if (ctl.walk_init) begin
			idx_q <= '0;
			row_q <= YW'(MATRIX_HEIGHT - 1);
			col_q <= XW'(MATRIX_WIDTH - 1);
		end else if (ctl.issue) begin
			idx_q <= idx_q + AW'(1);
			if (col_q == '0) begin
				col_q <= XW'(MATRIX_WIDTH - 1);
				row_q <= row_q - YW'(1);
			end else begin
				col_q <= col_q - XW'(1);
			end
		end
	end

	// Mark entries written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	// Store write and registered read into the output stage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[waddr] <= color_q;
		end
		if (ctl.issue) begin
			if (hit) begin
				data_s1 <= color_q;
			end else if (vld_q[idx_q]) begin
				data_s1 <= mem_q[idx_q];
			end else begin
				data_s1 <= '0;
			end
			last_s1 <= (idx_q == AW'(COUNT - 1));
		end
	end

	// Hold the output transaction until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ctl.issue) begin
			valid_s1 <= 1'b1;
		end else if (out_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	assign out_valid = valid_s1;
	assign out_green = data_s1.green;
	assign out_red   = data_s1.red;
	assign out_blue  = data_s1.blue;
	assign out_last  = last_s1;

endmodule
